// ===== design/jsu_pkg.sv =====
package jsu_pkg;

    localparam int MAX_RES = 6;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_UP_D  = 8'h44;
    localparam logic [7:0] CH_LO_D  = 8'h64;

    // utf-8 encoding constants
    localparam logic [15:0] CP_1B_LIMIT = 16'h0080;
    localparam logic [15:0] CP_2B_LIMIT = 16'h0800;
    localparam logic [15:0] HIGH_MIN    = 16'hD800;
    localparam logic [15:0] HIGH_MAX    = 16'hDBFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [7:0]  LEAD2       = 8'hC0;
    localparam logic [7:0]  LEAD3       = 8'hE0;
    localparam logic [7:0]  LEAD4       = 8'hF0;
    localparam logic [7:0]  CONT        = 8'h80;
    localparam logic [4:0]  HEX_BAD     = 5'd16;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_DONE,
        KIND_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NO_QUOTE,
        ERR_UNTERM_ESC,
        ERR_TRUNC_U,
        ERR_BAD_HEX,
        ERR_UNKNOWN_ESC,
        ERR_UNTERM_STR
    } err_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        err_t       error_code;
        logic       last;
    } res_item_t;

    typedef res_item_t [MAX_RES-1:0] res_arr_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] hex;
        logic [1:0]  dcnt;
        logic [9:0]  held;
        logic        hp;
        logic        bad;
    } dec_state_t;

    localparam dec_state_t ST_RESET = '{
        mode: MODE_IDLE, hex: 16'h0, dcnt: 2'd0, held: 10'h0, hp: 1'b0, bad: 1'b0
    };

endpackage

// ===== design/jsu_step.sv =====
module jsu_step
    import jsu_pkg::*;
(
    input  dec_state_t       st,
    input  byte_item_t       item,
    output dec_state_t       st_next,
    output res_arr_t         res,
    output logic [CNT_W-1:0] res_cnt
);

    function automatic void push(inout res_arr_t a, inout logic [CNT_W-1:0] n,
                                 input logic [7:0] val, input kind_t k, input err_t e);
        if (n < CNT_W'(MAX_RES))
        begin
            a[n].out_byte   = val;
            a[n].kind       = k;
            a[n].error_code = e;
            a[n].last       = 1'b0;
            n = n + 1'b1;
        end
    endfunction

    function automatic void put_cp(inout res_arr_t a, inout logic [CNT_W-1:0] n,
                                   input logic [15:0] cp);
        if (cp < CP_1B_LIMIT)
        begin
            push(a, n, cp[7:0], KIND_DATA, ERR_NO_QUOTE);
        end
        else if (cp < CP_2B_LIMIT)
        begin
            push(a, n, LEAD2 | {3'b0, cp[10:6]}, KIND_DATA, ERR_NO_QUOTE);
            push(a, n, CONT | {2'b0, cp[5:0]}, KIND_DATA, ERR_NO_QUOTE);
        end
        else
        begin
            push(a, n, LEAD3 | {4'b0, cp[15:12]}, KIND_DATA, ERR_NO_QUOTE);
            push(a, n, CONT | {2'b0, cp[11:6]}, KIND_DATA, ERR_NO_QUOTE);
            push(a, n, CONT | {2'b0, cp[5:0]}, KIND_DATA, ERR_NO_QUOTE);
        end
    endfunction

    // held high surrogate goes out as a plain 3-byte sequence
    function automatic void flush(inout res_arr_t a, inout logic [CNT_W-1:0] n,
                                  inout dec_state_t s);
        put_cp(a, n, HIGH_MIN | {6'b0, s.held});
        s.hp   = 1'b0;
        s.held = '0;
    endfunction

    function automatic void fail(inout res_arr_t a, inout logic [CNT_W-1:0] n,
                                 inout dec_state_t s, input err_t e);
        push(a, n, 8'h00, KIND_ERROR, e);
        s = ST_RESET;
    endfunction

    function automatic logic [4:0] hex_of(input logic [7:0] b);
        if (b inside {["0":"9"]})
            return {1'b0, b[3:0]};
        else if (b inside {["a":"f"], ["A":"F"]})
            return {1'b0, b[3:0] + 4'd9};
        else
            return HEX_BAD;
    endfunction

    always_comb
    begin : step_logic
        dec_state_t       s;
        res_arr_t         a;
        logic [CNT_W-1:0] n;
        logic [7:0]       b;
        logic             fin;
        logic [4:0]       d;
        logic [15:0]      hv;
        logic [20:0]      c;
        logic [7:0]       m;
        logic             m_ok;

        s    = st;
        a    = '0;
        n    = '0;
        b    = item.in_byte;
        fin  = item.end_of_text;
        d    = hex_of(b);
        hv   = {st.hex[11:0], d[3:0]};
        c    = SUPP_BASE + {1'b0, st.held, hv[9:0]};
        m    = 8'h00;
        m_ok = 1'b1;

        case (b)
            "\"":    m = CH_QUOTE;
            "\\":    m = CH_BSL;
            "/":     m = "/";
            "b":     m = 8'h08;
            "f":     m = 8'h0C;
            "n":     m = 8'h0A;
            "r":     m = 8'h0D;
            "t":     m = 8'h09;
            default: m_ok = 1'b0;
        endcase

        case (st.mode)
            MODE_STR:
            begin
                if (s.hp && !(b == CH_BSL && !fin))
                    flush(a, n, s);
                if (b == CH_QUOTE)
                begin
                    push(a, n, 8'h00, KIND_DONE, ERR_NO_QUOTE);
                    s = ST_RESET;
                end
                else if (b == CH_BSL)
                begin
                    if (fin)
                        fail(a, n, s, ERR_UNTERM_ESC);
                    else
                        s.mode = MODE_ESC;
                end
                else
                begin
                    push(a, n, b, KIND_DATA, ERR_NO_QUOTE);
                    if (fin)
                        fail(a, n, s, ERR_UNTERM_STR);
                end
            end
            MODE_ESC:
            begin
                if (s.hp && !(b == CH_U && !fin))
                    flush(a, n, s);
                if (m_ok)
                begin
                    push(a, n, m, KIND_DATA, ERR_NO_QUOTE);
                    s.mode = MODE_STR;
                    if (fin)
                        fail(a, n, s, ERR_UNTERM_STR);
                end
                else if (b == CH_U)
                begin
                    if (fin)
                        fail(a, n, s, ERR_TRUNC_U);
                    else
                    begin
                        s.mode = MODE_HEX;
                        s.hex  = '0;
                        s.dcnt = '0;
                        s.bad  = 1'b0;
                    end
                end
                else
                begin
                    fail(a, n, s, ERR_UNKNOWN_ESC);
                end
            end
            MODE_HEX:
            begin
                // a pair is only possible for \u D[C-F]xx after a held high half
                if (s.hp)
                begin
                    if (st.dcnt == 2'd0 && b != CH_UP_D && b != CH_LO_D)
                        flush(a, n, s);
                    else if (st.dcnt == 2'd1 && !(d >= 5'd12 && d <= 5'd15))
                        flush(a, n, s);
                end
                s.hex = hv;
                if (d[4])
                    s.bad = 1'b1;
                if (st.dcnt != 2'd3)
                begin
                    if (fin)
                    begin
                        if (s.hp)
                            flush(a, n, s);
                        fail(a, n, s, ERR_TRUNC_U);
                    end
                    else
                    begin
                        s.dcnt = st.dcnt + 2'd1;
                    end
                end
                else if (s.bad)
                begin
                    if (s.hp)
                        flush(a, n, s);
                    fail(a, n, s, ERR_BAD_HEX);
                end
                else if (s.hp)
                begin
                    push(a, n, LEAD4 | {5'b0, c[20:18]}, KIND_DATA, ERR_NO_QUOTE);
                    push(a, n, CONT | {2'b0, c[17:12]}, KIND_DATA, ERR_NO_QUOTE);
                    push(a, n, CONT | {2'b0, c[11:6]}, KIND_DATA, ERR_NO_QUOTE);
                    push(a, n, CONT | {2'b0, c[5:0]}, KIND_DATA, ERR_NO_QUOTE);
                    s.hp   = 1'b0;
                    s.held = '0;
                    s.mode = MODE_STR;
                    if (fin)
                        fail(a, n, s, ERR_UNTERM_STR);
                end
                else
                begin
                    s.mode = MODE_STR;
                    if (hv >= HIGH_MIN && hv <= HIGH_MAX && !fin)
                    begin
                        s.held = hv[9:0];
                        s.hp   = 1'b1;
                    end
                    else
                    begin
                        put_cp(a, n, hv);
                        if (fin)
                            fail(a, n, s, ERR_UNTERM_STR);
                    end
                end
            end
            default:
            begin
                if (b != CH_QUOTE)
                    fail(a, n, s, ERR_NO_QUOTE);
                else if (fin)
                    fail(a, n, s, ERR_UNTERM_STR);
                else
                begin
                    s      = ST_RESET;
                    s.mode = MODE_STR;
                end
            end
        endcase

        if (n != '0)
            a[n - 1'b1].last = 1'b1;

        st_next = s;
        res     = a;
        res_cnt = n;
    end

endmodule

// ===== design/json_string_unescape_decoder.sv =====
// channel   | direction | payload      | handshake
// ----------+-----------+--------------+------------------------------
// byte      | in        | byte_item_t  | byte_valid / byte_stall
// res       | out       | res_item_t   | res_valid  / res_stall
//
// one byte transaction is decoded in the cycle it is accepted; its 0 to 6
// results land in a result queue and leave one per cycle while res_stall is low
// a byte that gives at most one result is taken every cycle while res_stall is
// low; one that gives more results holds the byte side while the queue drains
// rst_n clears decoder state and empties the queue (awaiting opening quote)
// res_stall reaches byte_stall combinationally only on the final queued result
module json_string_unescape_decoder
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    output logic       res_valid,
    input  logic       res_stall,
    output res_item_t  res_item
);

    // decoder state carried from one byte to the next
    dec_state_t       state_reg;
    dec_state_t       state_next;

    // result queue: head at entry 0, shifts down as results are taken
    res_arr_t         queue_reg;
    res_arr_t         queue_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    res_arr_t         step_res;
    logic [CNT_W-1:0] step_cnt;
    logic             accept;
    logic             take;

    jsu_step u_step (
        .st      (state_reg),
        .item    (byte_item),
        .st_next (state_next),
        .res     (step_res),
        .res_cnt (step_cnt)
    );

    assign res_valid = (cnt_reg != '0);
    assign res_item  = queue_reg[0];
    assign take      = res_valid && !res_stall;

    // new byte only when the queue is empty or its last entry leaves now
    assign byte_stall = !((cnt_reg == '0) || (cnt_reg == CNT_W'(1) && !res_stall));
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        queue_next = queue_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            queue_next = step_res;
            cnt_next   = step_cnt;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
                queue_next[i] = queue_reg[i + 1];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RESET;
            cnt_reg   <= '0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

    // queue never holds more than one byte's worth of results
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RES))
        else $error("result queue count out of range");

    // the last flag marks exactly the final queued result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.last == (cnt_reg == CNT_W'(1))))
        else $error("last flag does not match queue position");

    // an error or completion result returns the decoder to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && step_cnt != '0 && step_res[step_cnt - 1'b1].kind != KIND_DATA
        |=> state_reg.mode == MODE_IDLE)
        else $error("decoder not idle after error or completion");

    // non-data results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.kind != KIND_DATA |-> res_item.out_byte == 8'h00)
        else $error("non-data result carries a byte");

    // a taken result that is not last leaves the next one queued
    assert property (@(posedge clk) disable iff (!rst_n)
        take && !res_item.last |=> res_valid)
        else $error("result queue drained early");

endmodule
